/* hw/rtl/tensor_permute_address_gen_defines.svh */
// assertion macros for the tensor permute address generator
// used by tensor_permute_address_gen; assumes clk and rst in scope
`ifndef TENSOR_PERMUTE_ADDRESS_GEN_DEFINES_SVH
`define TENSOR_PERMUTE_ADDRESS_GEN_DEFINES_SVH
`ifndef SYNTHESIS
`define TPAG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tpag assertion failed");
`define TPAG_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("tpag assertion failed");
`else
`define TPAG_ASSERT(lbl, prop)
`define TPAG_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

/* hw/rtl/tpag_pkg.sv */
// shared types and constants of the tensor permute address generator
// no dependencies
`timescale 1ns / 1ps
package tpag_pkg;
  localparam int MAX_DIMS = 4;
  localparam int DIV_STEPS = 32;
  localparam int NUM_CELLS = 2 * DIV_STEPS;
  localparam int NUM_REGS = 8;

  localparam logic [2:0] REG_NUM_DIMS = 3'd0;
  localparam logic [2:0] REG_DIM0 = 3'd1;
  localparam logic [2:0] REG_DIM1 = 3'd2;
  localparam logic [2:0] REG_DIM2 = 3'd3;
  localparam logic [2:0] REG_DIM3 = 3'd4;
  localparam logic [2:0] REG_PERM = 3'd5;
  localparam logic [2:0] REG_DST_BS = 3'd6;
  localparam logic [2:0] REG_SRC_BS = 3'd7;

  typedef struct packed {
    logic [2:0] num_dims;
    logic [MAX_DIMS-1:0][63:0] desc;
    logic [7:0] perm;
    logic [31:0] dst_bs;
    logic [31:0] src_bs;
  } tpag_cfg_t;

  typedef struct packed {
    logic valid;
    logic keep;
    logic [15:0] batch;
    logic [MAX_DIMS-1:0][31:0] rem;
    logic [MAX_DIMS-1:0][31:0] word;
  } tpag_stage_t;

  typedef struct packed {
    logic valid;
    logic [31:0] src;
    logic [31:0] dst;
  } tpag_result_t;
endpackage

/* hw/rtl/tpag_in_if.sv */
// input channel interface
// depends on nothing
`timescale 1ns / 1ps
interface tpag_in_if;
  logic valid;
  logic ready;
  logic [15:0] batch_index;
  logic [31:0] element_index;
  modport source (output valid, batch_index, element_index, input ready);
  modport sink (input valid, batch_index, element_index, output ready);
endinterface

/* hw/rtl/tpag_out_if.sv */
// result channel interface
// depends on nothing
`timescale 1ns / 1ps
interface tpag_out_if;
  logic valid;
  logic ready;
  logic [31:0] src_address;
  logic [31:0] dst_address;
  modport source (output valid, src_address, dst_address, input ready);
  modport sink (input valid, src_address, dst_address, output ready);
endinterface

/* hw/rtl/tpag_div_cell.sv */
// one restoring division step for every dimension lane
// depends on tpag_pkg
`timescale 1ns / 1ps
module tpag_div_cell (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic [tpag_pkg::MAX_DIMS-1:0][31:0] divisor,
  input  tpag_pkg::tpag_stage_t stage_in,
  output tpag_pkg::tpag_stage_t stage_out
);
  import tpag_pkg::*;

  tpag_stage_t stage_next;
  logic [MAX_DIMS-1:0][32:0] trial;
  logic [MAX_DIMS-1:0][32:0] diff;

  always_comb begin
    stage_next = stage_in;
    for (int i = 0; i < MAX_DIMS; i++) begin
      trial[i] = {stage_in.rem[i], stage_in.word[i][31]};
      diff[i] = trial[i] - {1'b0, divisor[i]};
      if (trial[i] >= {1'b0, divisor[i]}) begin
        stage_next.rem[i] = diff[i][31:0];
        stage_next.word[i] = {stage_in.word[i][30:0], 1'b1};
      end else begin
        stage_next.rem[i] = trial[i][31:0];
        stage_next.word[i] = {stage_in.word[i][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (en) begin
      stage_out.valid <= stage_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_out.keep <= stage_next.keep;
      stage_out.batch <= stage_next.batch;
      stage_out.rem <= stage_next.rem;
      stage_out.word <= stage_next.word;
    end
  end
endmodule

/* hw/rtl/tpag_mac.sv */
// coordinate masking, stride products and address sums
// depends on tpag_pkg
`timescale 1ns / 1ps
module tpag_mac (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  tpag_pkg::tpag_cfg_t cfg,
  input  tpag_pkg::tpag_stage_t stage_in,
  output tpag_pkg::tpag_result_t result
);
  import tpag_pkg::*;

  logic [2:0] used;
  logic [MAX_DIMS-1:0][15:0] coord_next;
  logic p1_v;
  logic [MAX_DIMS-1:0][15:0] p1_coord;
  logic [15:0] p1_batch;
  logic p2_v;
  logic [MAX_DIMS:0][31:0] p2_src;
  logic [MAX_DIMS:0][31:0] p2_dst;
  logic p3_v;
  logic [2:0][31:0] p3_src;
  logic [2:0][31:0] p3_dst;
  logic [1:0] psel [MAX_DIMS];
  logic [39:0] src_prod [MAX_DIMS];
  logic [39:0] dst_prod [MAX_DIMS];
  logic [47:0] src_base;
  logic [47:0] dst_base;

  always_comb begin
    used = (cfg.num_dims > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : cfg.num_dims;
    for (int i = 0; i < MAX_DIMS; i++) begin
      // coordinate is zero for unused lanes and zero sizes or strides
      if ((3'(i) < used) && (cfg.desc[i][39:16] != '0) && (cfg.desc[i][15:0] != '0)) begin
        coord_next[i] = stage_in.rem[i][15:0];
      end else begin
        coord_next[i] = '0;
      end
      psel[i] = cfg.perm[2*i +: 2];
      src_prod[i] = p1_coord[i] * cfg.desc[psel[i]][63:40];
      dst_prod[i] = p1_coord[i] * cfg.desc[i][39:16];
    end
    src_base = p1_batch * cfg.src_bs;
    dst_base = p1_batch * cfg.dst_bs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      p1_v <= stage_in.valid & stage_in.keep;
      p2_v <= p1_v;
      p3_v <= p2_v;
      result.valid <= p3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_coord <= coord_next;
      p1_batch <= stage_in.batch;
      for (int i = 0; i < MAX_DIMS; i++) begin
        p2_src[i] <= src_prod[i][31:0];
        p2_dst[i] <= dst_prod[i][31:0];
      end
      p2_src[MAX_DIMS] <= src_base[31:0];
      p2_dst[MAX_DIMS] <= dst_base[31:0];
      p3_src[0] <= p2_src[0] + p2_src[1];
      p3_src[1] <= p2_src[2] + p2_src[3];
      p3_src[2] <= p2_src[4];
      p3_dst[0] <= p2_dst[0] + p2_dst[1];
      p3_dst[1] <= p2_dst[2] + p2_dst[3];
      p3_dst[2] <= p2_dst[4];
      result.src <= p3_src[0] + p3_src[1] + p3_src[2];
      result.dst <= p3_dst[0] + p3_dst[1] + p3_dst[2];
    end
  end
endmodule

/* hw/rtl/tensor_permute_address_gen.sv */
// channel     dir  payload
// in_ch       in   batch_index[15:0], element_index[31:0]
// out_ch      out  src_address[31:0], dst_address[31:0]
// cfg_*       in   cfg_index[2:0], cfg_data[63:0]
// one transaction per cycle while the skid entry is empty; input is registered through
// a chain of 64 division cells (32 for the quotient, 32 for the modulo), the MAC
// stages and the output register; elements past the tensor length leave no result
// synchronous reset clears valid flags and loads register defaults
// a two-entry output buffer lets the chain run while a result waits
`timescale 1ns / 1ps
`include "tensor_permute_address_gen_defines.svh"
module tensor_permute_address_gen (
  input  logic clk,
  input  logic rst,
  tpag_in_if.sink in_ch,
  tpag_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data
);
  import tpag_pkg::*;

  tpag_cfg_t cfg;
  tpag_stage_t st [NUM_CELLS+1];
  tpag_stage_t mid;
  tpag_result_t fin;
  logic en;
  logic out_v;
  logic [31:0] out_src;
  logic [31:0] out_dst;
  logic skid_v;
  logic [31:0] skid_src;
  logic [31:0] skid_dst;
  logic [MAX_DIMS-1:0][31:0] div_stride;
  logic [MAX_DIMS-1:0][31:0] div_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_dims <= 3'd1;
      cfg.desc <= '0;
      cfg.perm <= 8'd228;
      cfg.dst_bs <= '0;
      cfg.src_bs <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_DIMS: cfg.num_dims <= cfg_data[2:0];
        REG_DIM0: cfg.desc[0] <= cfg_data;
        REG_DIM1: cfg.desc[1] <= cfg_data;
        REG_DIM2: cfg.desc[2] <= cfg_data;
        REG_DIM3: cfg.desc[3] <= cfg_data;
        REG_PERM: cfg.perm <= cfg_data[7:0];
        REG_DST_BS: cfg.dst_bs <= cfg_data[31:0];
        REG_SRC_BS: cfg.src_bs <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign en = !skid_v;
  assign in_ch.ready = en;

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      div_stride[i] = {8'd0, cfg.desc[i][39:16]};
      div_size[i] = {16'd0, cfg.desc[i][15:0]};
    end
    st[0].valid = in_ch.valid;
    st[0].keep = in_ch.element_index < cfg.dst_bs;
    st[0].batch = in_ch.batch_index;
    st[0].rem = '0;
    st[0].word = {MAX_DIMS{in_ch.element_index}};
    // quotient becomes the dividend of the modulo half
    mid = st[DIV_STEPS];
    mid.rem = '0;
  end

  genvar k;
  generate
    for (k = 0; k < NUM_CELLS; k++) begin : g_cell
      if (k < DIV_STEPS) begin : g_quo
        tpag_div_cell u_cell (
          .clk(clk), .rst(rst), .en(en), .divisor(div_stride),
          .stage_in(st[k]), .stage_out(st[k+1])
        );
      end else if (k == DIV_STEPS) begin : g_mid
        tpag_div_cell u_cell (
          .clk(clk), .rst(rst), .en(en), .divisor(div_size),
          .stage_in(mid), .stage_out(st[k+1])
        );
      end else begin : g_mod
        tpag_div_cell u_cell (
          .clk(clk), .rst(rst), .en(en), .divisor(div_size),
          .stage_in(st[k]), .stage_out(st[k+1])
        );
      end
    end
  endgenerate

  tpag_mac u_mac (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .stage_in(st[NUM_CELLS]), .result(fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (out_ch.ready) begin
        skid_v <= 1'b0;
      end
    end else if (fin.valid) begin
      if (!out_v || out_ch.ready) begin
        out_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (out_ch.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_ch.ready) begin
        out_src <= skid_src;
        out_dst <= skid_dst;
      end
    end else if (fin.valid) begin
      if (!out_v || out_ch.ready) begin
        out_src <= fin.src;
        out_dst <= fin.dst;
      end else begin
        skid_src <= fin.src;
        skid_dst <= fin.dst;
      end
    end
  end

  assign out_ch.valid = out_v;
  assign out_ch.src_address = out_src;
  assign out_ch.dst_address = out_dst;

  `TPAG_ASSERT(a_skid_needs_out, !skid_v || out_v)
  `TPAG_ASSERT(a_skid_blocks_input, !skid_v || !in_ch.ready)
  `TPAG_ASSERT_NEXT(a_reset_clears, rst, !out_v && !skid_v)
endmodule
